// ===== design/kmva_pkg.sv =====
// Package for the keyed meter value averager.
// Command codes, measurand codes, field widths and key table helpers.
// No dependencies.
package kmva_pkg;

    localparam int CMD_W   = 2;
    localparam int MEAS_W  = 5;
    localparam int PHASE_W = 4;
    localparam int LOC_W   = 3;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 32;

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    localparam logic [MEAS_W-1:0] MEAS_CURRENT_IMPORT      = 5'd1;
    localparam logic [MEAS_W-1:0] MEAS_VOLTAGE             = 5'd2;
    localparam logic [MEAS_W-1:0] MEAS_POWER_ACTIVE_IMPORT = 5'd3;
    localparam logic [MEAS_W-1:0] MEAS_FREQUENCY           = 5'd4;

    localparam int NUM_PHASES    = 11;
    localparam int NUM_LOCATIONS = 6;
    localparam int KEYS_PER_MEAS = NUM_PHASES * NUM_LOCATIONS;
    localparam int NUM_KEYS      = 4 * KEYS_PER_MEAS;
    localparam int KEY_AW        = $clog2(NUM_KEYS);
    localparam int KEY_DW        = SUM_W + CNT_W;
    localparam int SMP_DW        = MEAS_W + PHASE_W + LOC_W + VAL_W;

    localparam int MAX_SAMPLES_DEF = 32;

    typedef struct packed {
        logic [MEAS_W-1:0]       meas;
        logic [PHASE_W-1:0]      ph;
        logic [LOC_W-1:0]        loc;
        logic signed [VAL_W-1:0] val;
    } t_sample;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
    } t_key_entry;

    function automatic logic key_valid(input logic [MEAS_W-1:0] meas,
                                       input logic [PHASE_W-1:0] ph,
                                       input logic [LOC_W-1:0] loc);
        key_valid = (meas >= MEAS_CURRENT_IMPORT) && (meas <= MEAS_FREQUENCY) &&
                    (ph < PHASE_W'(NUM_PHASES)) && (loc < LOC_W'(NUM_LOCATIONS));
    endfunction

    function automatic logic [KEY_AW-1:0] key_index(input logic [MEAS_W-1:0] meas,
                                                    input logic [PHASE_W-1:0] ph,
                                                    input logic [LOC_W-1:0] loc);
        logic [KEY_AW-1:0] m1;
        m1 = KEY_AW'(meas) - KEY_AW'(1);
        key_index = m1 * KEY_AW'(KEYS_PER_MEAS) + KEY_AW'(ph) * KEY_AW'(NUM_LOCATIONS)
                    + KEY_AW'(loc);
    endfunction

endpackage

// ===== design/kmva_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kmva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/keyed_meter_value_averager.sv =====
// Keyed meter value averager: per-key saturating sums and counts, stored
// sample list, replay with averages. Depends on kmva_pkg and kmva_ram.
//
// One item is taken at a time; o_in_ready is high only while the block is
// idle. An add on an averaged key does one read-modify-write of the key
// table RAM (state S_ADD); an add on any other key leaves the table alone.
// A clear zeroes the 264 key table entries, one entry per cycle; the same
// clearing pass runs after reset before the first item is taken.
// A retrieve produces one result per stored sample; each result passes
// through the sample and key RAM reads (S_RDS, S_KEY, S_KWAIT) plus, for
// an averaged key with a nonzero count, the bit-serial divider (48
// quotient bits in S_DIV and one saturate step in S_FIN), before it is
// offered on the output; the block waits as long as the output stays
// stalled. Retrieve on an empty list and command code 3 finish with no result.
module keyed_meter_value_averager #(
    parameter int MAX_SAMPLES = kmva_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [kmva_pkg::CMD_W-1:0]          i_cmd,
    input  logic                                i_first_of_message,
    input  logic [kmva_pkg::MEAS_W-1:0]         i_measurand,
    input  logic [kmva_pkg::PHASE_W-1:0]        i_phase,
    input  logic [kmva_pkg::LOC_W-1:0]          i_location,
    input  logic signed [kmva_pkg::VAL_W-1:0]   i_sample_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [kmva_pkg::MEAS_W-1:0]         o_out_measurand,
    output logic [kmva_pkg::PHASE_W-1:0]        o_out_phase,
    output logic [kmva_pkg::LOC_W-1:0]          o_out_location,
    output logic signed [kmva_pkg::VAL_W-1:0]   o_out_value,
    output logic                                o_last
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int SUM_W = kmva_pkg::SUM_W;
    localparam int CNT_W = kmva_pkg::CNT_W;
    localparam int VAL_W = kmva_pkg::VAL_W;
    localparam int KEY_AW = kmva_pkg::KEY_AW;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_RDS   = 4'd3;
    localparam logic [3:0] S_KEY   = 4'd4;
    localparam logic [3:0] S_KWAIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]               r_state, n_state;
    logic [KEY_AW-1:0]        r_clr_addr, n_clr_addr;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_k, n_k;
    logic [KEY_AW-1:0]        r_kidx, n_kidx;
    logic                     r_kvld, n_kvld;
    logic signed [VAL_W-1:0]  r_add_val, n_add_val;
    kmva_pkg::t_sample        r_smp, n_smp;
    logic signed [VAL_W-1:0]  r_out_value, n_out_value;
    logic [CNT_W-1:0]         r_rem, n_rem;
    logic [SUM_W-1:0]         r_quo, n_quo;
    logic [CNT_W-1:0]         r_div, n_div;
    logic                     r_neg, n_neg;
    logic [STEP_W-1:0]        r_step, n_step;

    // key table RAM
    logic                     key_we;
    logic [KEY_AW-1:0]        key_waddr;
    kmva_pkg::t_key_entry     key_wdata;
    logic [KEY_AW-1:0]        key_raddr;
    kmva_pkg::t_key_entry     key_rdata;

    // sample list RAM
    logic                     smp_we;
    logic [AW-1:0]            smp_waddr;
    kmva_pkg::t_sample        smp_wdata;
    kmva_pkg::t_sample        smp_rdata;

    kmva_ram #(.WIDTH(kmva_pkg::KEY_DW), .DEPTH(kmva_pkg::NUM_KEYS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    kmva_ram #(.WIDTH(kmva_pkg::SMP_DW), .DEPTH(MAX_SAMPLES)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (smp_waddr),
        .i_wdata (smp_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (smp_rdata)
    );

    logic                     in_xfer;
    logic [CW-1:0]            base_count;
    logic                     in_kvld;
    logic [KEY_AW-1:0]        in_kidx;
    logic [KEY_AW-1:0]        smp_kidx;
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SUM_W-1:0]  sum_sat;
    logic [CNT_W-1:0]         cnt_inc;
    logic [CNT_W:0]           div_t;
    logic [CNT_W+1:0]         div_diff;
    logic                     div_ge;
    logic [SUM_W-1:0]         sum_mag;
    logic                     is_last;

    assign o_in_ready      = (r_state == S_IDLE);
    assign in_xfer         = i_in_valid && o_in_ready;
    assign o_out_valid     = (r_state == S_OUT);
    assign o_out_measurand = r_smp.meas;
    assign o_out_phase     = r_smp.ph;
    assign o_out_location  = r_smp.loc;
    assign o_out_value     = r_out_value;
    assign is_last         = ((r_k + CW'(1)) == r_count);
    assign o_last          = is_last;

    assign base_count = i_first_of_message ? '0 : r_count;
    assign in_kvld    = kmva_pkg::key_valid(i_measurand, i_phase, i_location);
    assign in_kidx    = kmva_pkg::key_index(i_measurand, i_phase, i_location);
    assign smp_kidx   = kmva_pkg::key_index(smp_rdata.meas, smp_rdata.ph, smp_rdata.loc);
    assign key_raddr  = (r_state == S_KEY) ? smp_kidx : in_kidx;

    assign smp_we          = in_xfer && (i_cmd == kmva_pkg::CMD_ADD) &&
                             (base_count < CW'(MAX_SAMPLES));
    assign smp_waddr       = base_count[AW-1:0];
    assign smp_wdata.meas  = i_measurand;
    assign smp_wdata.ph    = i_phase;
    assign smp_wdata.loc   = i_location;
    assign smp_wdata.val   = i_sample_value;

    // saturating accumulate
    assign sum_ext = {key_rdata.sum[SUM_W-1], key_rdata.sum} +
                     (SUM_W+1)'(r_add_val);
    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end
    assign cnt_inc = (&key_rdata.cnt) ? key_rdata.cnt : key_rdata.cnt + CNT_W'(1);

    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_kidx;
        key_wdata = '{sum: sum_sat, cnt: cnt_inc};
        if (r_state == S_CLR) begin
            key_we    = 1'b1;
            key_waddr = r_clr_addr;
            key_wdata = '0;
        end else if (r_state == S_ADD) begin
            key_we = 1'b1;
        end
    end

    // one restoring divide step
    assign div_t    = {r_rem, r_quo[SUM_W-1]};
    assign div_diff = {1'b0, div_t} - {2'b00, r_div};
    assign div_ge   = !div_diff[CNT_W+1];
    assign sum_mag  = key_rdata.sum[SUM_W-1] ? SUM_W'(-key_rdata.sum) : key_rdata.sum;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_k         = r_k;
        n_kidx      = r_kidx;
        n_kvld      = r_kvld;
        n_add_val   = r_add_val;
        n_smp       = r_smp;
        n_out_value = r_out_value;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_neg       = r_neg;
        n_step      = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_cmd == kmva_pkg::CMD_ADD) begin
                        n_count   = smp_we ? base_count + CW'(1) : base_count;
                        n_kidx    = in_kidx;
                        n_add_val = i_sample_value;
                        if (in_kvld) begin
                            n_state = S_ADD;
                        end
                    end else if (i_cmd == kmva_pkg::CMD_RETRIEVE) begin
                        n_k = '0;
                        if (r_count != '0) begin
                            n_state = S_RDS;
                        end
                    end else if (i_cmd == kmva_pkg::CMD_CLEAR) begin
                        n_count    = '0;
                        n_clr_addr = '0;
                        n_state    = S_CLR;
                    end
                end
            end
            S_CLR: begin
                n_clr_addr = r_clr_addr + KEY_AW'(1);
                if (r_clr_addr == KEY_AW'(kmva_pkg::NUM_KEYS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
            end
            S_RDS: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                n_smp   = smp_rdata;
                n_kvld  = kmva_pkg::key_valid(smp_rdata.meas, smp_rdata.ph, smp_rdata.loc);
                n_state = S_KWAIT;
            end
            S_KWAIT: begin
                if (r_kvld && (key_rdata.cnt != '0)) begin
                    n_rem   = '0;
                    n_quo   = sum_mag;
                    n_div   = key_rdata.cnt;
                    n_neg   = key_rdata.sum[SUM_W-1];
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_out_value = r_smp.val;
                    n_state     = S_OUT;
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
                n_quo  = {r_quo[SUM_W-2:0], div_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_neg) begin
                    if (r_quo > SUM_W'(64'h8000_0000)) begin
                        n_out_value = {1'b1, {(VAL_W-1){1'b0}}};
                    end else begin
                        n_out_value = -r_quo[VAL_W-1:0];
                    end
                end else begin
                    if (r_quo > SUM_W'(64'h7FFF_FFFF)) begin
                        n_out_value = {1'b0, {(VAL_W-1){1'b1}}};
                    end else begin
                        n_out_value = r_quo[VAL_W-1:0];
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RDS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kidx      <= n_kidx;
        r_kvld      <= n_kvld;
        r_add_val   <= n_add_val;
        r_smp       <= n_smp;
        r_out_value <= n_out_value;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div       <= n_div;
        r_neg       <= n_neg;
        r_step      <= n_step;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("stored sample count above list depth");

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_last_ends_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> (r_state == S_IDLE))
        else $error("replay continued after final sample");

    a_replay_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_k < r_count))
        else $error("replay index beyond stored list");

endmodule

// ===== bench/kmva_checker.sv =====
// Checker for the keyed meter value averager: watches both channels, keeps its
// own key table and sample list, and compares every output transfer.
// Depends on kmva_pkg.
module kmva_checker
    import kmva_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic                      i_first_of_message,
    input  logic [MEAS_W-1:0]         i_measurand,
    input  logic [PHASE_W-1:0]        i_phase,
    input  logic [LOC_W-1:0]          i_location,
    input  logic signed [VAL_W-1:0]   i_sample_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [MEAS_W-1:0]         i_out_measurand,
    input  logic [PHASE_W-1:0]        i_out_phase,
    input  logic [LOC_W-1:0]          i_out_location,
    input  logic signed [VAL_W-1:0]   i_out_value,
    input  logic                      i_out_last,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));
    localparam longint AVG_HI = 64'sd2147483647;
    localparam longint AVG_LO = -64'sd2147483648;

    typedef struct {
        logic [MEAS_W-1:0]       meas;
        logic [PHASE_W-1:0]      ph;
        logic [LOC_W-1:0]        loc;
        logic signed [VAL_W-1:0] val;
        logic                    last;
    } t_replay;

    logic signed [SUM_W-1:0] key_sum [NUM_KEYS];
    logic [CNT_W-1:0]        key_cnt [NUM_KEYS];
    t_sample                 msg_list [MAX_SAMPLES];
    int                      msg_len = 0;
    t_replay                 replay_q [$];
    int                      fails = 0;

    function automatic bit averaged_slot(input logic [MEAS_W-1:0] meas,
                                         input logic [PHASE_W-1:0] ph,
                                         input logic [LOC_W-1:0] loc,
                                         output int slot);
        slot = (int'(meas) - 1) * KEYS_PER_MEAS + int'(ph) * NUM_LOCATIONS + int'(loc);
        return (meas >= MEAS_CURRENT_IMPORT) && (meas <= MEAS_FREQUENCY) &&
               (int'(ph) < NUM_PHASES) && (int'(loc) < NUM_LOCATIONS);
    endfunction

    task automatic wipe_all();
        foreach (key_sum[k]) begin
            key_sum[k] = '0;
            key_cnt[k] = '0;
        end
        msg_len = 0;
    endtask

    task automatic add_sample(input t_sample smp, input logic first);
        int     slot;
        longint total;
        if (first)
            msg_len = 0;
        if (msg_len < MAX_SAMPLES) begin
            msg_list[msg_len] = smp;
            msg_len++;
        end
        if (averaged_slot(smp.meas, smp.ph, smp.loc, slot)) begin
            total = longint'(key_sum[slot]) + longint'($signed(smp.val));
            if (total > SUM_HI)
                total = SUM_HI;
            if (total < SUM_LO)
                total = SUM_LO;
            key_sum[slot] = total[SUM_W-1:0];
            if (key_cnt[slot] != '1)
                key_cnt[slot]++;
        end
    endtask

    task automatic queue_replay();
        int      slot;
        int      k;
        longint  avg;
        t_replay r;
        for (k = 0; k < msg_len; k++) begin
            avg = longint'($signed(msg_list[k].val));
            if (averaged_slot(msg_list[k].meas, msg_list[k].ph, msg_list[k].loc, slot) &&
                key_cnt[slot] != '0) begin
                // signed division truncates toward zero
                avg = longint'(key_sum[slot]) / longint'(key_cnt[slot]);
                if (avg > AVG_HI)
                    avg = AVG_HI;
                if (avg < AVG_LO)
                    avg = AVG_LO;
            end
            r.meas = msg_list[k].meas;
            r.ph   = msg_list[k].ph;
            r.loc  = msg_list[k].loc;
            r.val  = avg[VAL_W-1:0];
            r.last = (k == msg_len - 1);
            replay_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            fails++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_replay want;
        if (!i_rst_n) begin
            wipe_all();
            replay_q.delete();
        end else begin
            // results drain before a new transfer can add expectations
            if (i_out_valid && i_out_ready) begin
                if (replay_q.size() == 0) begin
                    fails++;
                    $error("result transfer with no expected result pending");
                end else begin
                    want = replay_q.pop_front();
                    check_field("out_measurand", want.meas, i_out_measurand);
                    check_field("out_phase", want.ph, i_out_phase);
                    check_field("out_location", want.loc, i_out_location);
                    check_field("out_value", want.val, i_out_value);
                    check_field("last", want.last, i_out_last);
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_cmd)
                    CMD_ADD: begin
                        add_sample('{i_measurand, i_phase, i_location, i_sample_value},
                                   i_first_of_message);
                    end
                    CMD_RETRIEVE: begin
                        queue_replay();
                    end
                    CMD_CLEAR: begin
                        wipe_all();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= replay_q.size();
    end

endmodule

// ===== bench/keyed_meter_value_averager_tb.sv =====
// Testbench top for the keyed meter value averager: clock, reset, stimulus
// and output back-pressure; checking is done by kmva_checker.
// Depends on kmva_pkg, keyed_meter_value_averager and kmva_checker.
module keyed_meter_value_averager_tb;
    import kmva_pkg::*;

    localparam logic [CMD_W-1:0]        CMD_UNUSED  = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MAX     = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN     = 32'sh80000000;
    localparam int                      RAND_ITEMS  = 400;
    localparam int                      TAIL_CYCLES = 300;
    localparam int                      CYCLE_LIMIT = 3000000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_cmd = CMD_ADD;
    logic                      i_first_of_message = 1'b0;
    logic [MEAS_W-1:0]         i_measurand = '0;
    logic [PHASE_W-1:0]        i_phase = '0;
    logic [LOC_W-1:0]          i_location = '0;
    logic signed [VAL_W-1:0]   i_sample_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [MEAS_W-1:0]         o_out_measurand;
    logic [PHASE_W-1:0]        o_out_phase;
    logic [LOC_W-1:0]          o_out_location;
    logic signed [VAL_W-1:0]   o_out_value;
    logic                      o_last;

    int fail_count;
    int pending;
    int sent = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;

    keyed_meter_value_averager #(
        .MAX_SAMPLES(MAX_SAMPLES_DEF)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_first_of_message (i_first_of_message),
        .i_measurand        (i_measurand),
        .i_phase            (i_phase),
        .i_location         (i_location),
        .i_sample_value     (i_sample_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_measurand    (o_out_measurand),
        .o_out_phase        (o_out_phase),
        .o_out_location     (o_out_location),
        .o_out_value        (o_out_value),
        .o_last             (o_last)
    );

    kmva_checker #(
        .MAX_SAMPLES(MAX_SAMPLES_DEF)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_first_of_message (i_first_of_message),
        .i_measurand        (i_measurand),
        .i_phase            (i_phase),
        .i_location         (i_location),
        .i_sample_value     (i_sample_value),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_out_measurand    (o_out_measurand),
        .i_out_phase        (o_out_phase),
        .i_out_location     (o_out_location),
        .i_out_value        (o_out_value),
        .i_out_last         (o_last),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL keyed_meter_value_averager");
            $finish;
        end
    end

    // output back-pressure: a random stall before each result transfer
    initial begin
        int stall;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready))
                @(posedge i_clk);
        end
    end

    task automatic drive_item(input logic [CMD_W-1:0] cmd, input logic first,
                              input logic [MEAS_W-1:0] meas,
                              input logic [PHASE_W-1:0] ph,
                              input logic [LOC_W-1:0] loc,
                              input logic signed [VAL_W-1:0] val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_cmd              <= cmd;
        i_first_of_message <= first;
        i_measurand        <= meas;
        i_phase            <= ph;
        i_location         <= loc;
        i_sample_value     <= val;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready))
            @(posedge i_clk);
        sent++;
    endtask

    // non-add commands carry random don't-care fields
    task automatic drive_cmd(input logic [CMD_W-1:0] cmd);
        drive_item(cmd, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                   4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), $urandom);
    endtask

    // keys are drawn mostly from a small set so that averages build up
    task automatic add_random(input logic first);
        logic [MEAS_W-1:0]       meas;
        logic [PHASE_W-1:0]      ph;
        logic [LOC_W-1:0]        loc;
        logic signed [VAL_W-1:0] val;
        meas = ($urandom_range(0, 15) < 12) ? 5'($urandom_range(1, 4))
                                            : 5'($urandom_range(0, 31));
        ph   = ($urandom_range(0, 15) < 13) ? 4'($urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
        loc  = ($urandom_range(0, 15) < 13) ? 3'($urandom_range(0, 5))
                                            : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0: val = VAL_MAX;
            1: val = VAL_MIN;
            2: val = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            default: val = $urandom;
        endcase
        drive_item(CMD_ADD, first, meas, ph, loc, val);
    endtask

    initial begin
        int len;
        int k;
        int msg_no;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        drive_cmd(CMD_RETRIEVE);
        drive_cmd(CMD_UNUSED);
        drive_item(CMD_ADD, 1'b1, MEAS_CURRENT_IMPORT, 4'd0, 3'd0, VAL_MAX);
        drive_item(CMD_ADD, 1'b0, MEAS_CURRENT_IMPORT, 4'd0, 3'd0, VAL_MAX);
        drive_item(CMD_ADD, 1'b0, MEAS_VOLTAGE, 4'd10, 3'd5, VAL_MIN);
        drive_item(CMD_ADD, 1'b0, MEAS_VOLTAGE, 4'd10, 3'd5, -32'sd1);
        drive_item(CMD_ADD, 1'b0, MEAS_FREQUENCY, 4'd15, 3'd7, 32'sh12345678);
        drive_item(CMD_ADD, 1'b0, MEAS_POWER_ACTIVE_IMPORT, 4'd11, 3'd0, -32'sd7);
        drive_item(CMD_ADD, 1'b0, MEAS_POWER_ACTIVE_IMPORT, 4'd1, 3'd6, 32'sd5);
        drive_item(CMD_ADD, 1'b0, 5'd0, 4'd0, 3'd0, 32'sd123);
        drive_item(CMD_ADD, 1'b0, 5'd31, 4'd3, 3'd2, -32'sd123);
        drive_item(CMD_ADD, 1'b0, MEAS_POWER_ACTIVE_IMPORT, 4'd2, 3'd3, -32'sd7);
        drive_item(CMD_ADD, 1'b0, MEAS_POWER_ACTIVE_IMPORT, 4'd2, 3'd3, 32'sd4);
        drive_cmd(CMD_RETRIEVE);
        drive_cmd(CMD_UNUSED);
        drive_cmd(CMD_RETRIEVE);
        drive_item(CMD_ADD, 1'b1, MEAS_VOLTAGE, 4'd10, 3'd5, 32'sd0);
        drive_cmd(CMD_RETRIEVE);
        drive_cmd(CMD_CLEAR);
        drive_cmd(CMD_RETRIEVE);
        drive_item(CMD_ADD, 1'b0, MEAS_FREQUENCY, 4'd5, 3'd1, 32'sd1);
        drive_cmd(CMD_RETRIEVE);

        // random messages, a few long enough to overflow the sample list
        msg_no = 0;
        while (sent < RAND_ITEMS + 22) begin
            if ($urandom_range(0, 5) == 0)
                quiet = ~quiet;
            len = (msg_no == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(30, 40)
                                                             : $urandom_range(1, 8);
            for (k = 0; k < len; k++)
                add_random(k == 0 && $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 7) != 0)
                drive_cmd(CMD_RETRIEVE);
            case ($urandom_range(0, 11))
                0: drive_cmd(CMD_CLEAR);
                1: drive_cmd(CMD_UNUSED);
                2: drive_cmd(CMD_RETRIEVE);
                default: begin
                end
            endcase
            msg_no++;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS keyed_meter_value_averager");
        else
            $display("FAIL keyed_meter_value_averager");
        $finish;
    end

endmodule
